FILE: sv/prd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg: shared constants for the palette run-length row decoder
// Item modes, register codes, palette geometry and reset values.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned PAL_DEPTH  = 128;
  localparam int unsigned INDEX_BITS = 7;
  localparam int unsigned RGB_BITS   = 24;
  localparam int unsigned REG_BITS   = 12;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // s_tuser codes
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_STREAM  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_WIDTH    = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [REG_BITS-1:0] ROW_WIDTH_RESET    = 12'd512;
  localparam logic [REG_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd384;

endpackage
`default_nettype wire

FILE: sv/prd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_ram: generic single-port-write, single-port-read RAM
// Registered read with read enable; read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module prd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/palette_rle_row_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_rle_row_decoder_unit: palettized run-length row decoder
// Takes one compressed byte or palette write per transfer and emits one run
// per complete code with its color, length, row and start column.
// ----------------------------------------------------------------------------
//
//  channel   dir  contents
//  s_axis    in   tdata {palette_rgb, palette_index, byte_value}, tuser mode
//  m_axis    out  tdata {start_column, row_number, run_length, pixel_argb},
//                 tuser {overrun, row_done}, tlast image_done
//  apb       in   row_width @0x0, image_height @0x4
//
//  One item per cycle while m_axis is not stalled. A run passes through the
//  palette RAM read and then the output register on its way to m_axis.
//  Row/column counters update at input transfer, so only the palette read is
//  in the pipeline. Synchronous active-high reset; the palette is not cleared.
//  A stalled m_axis backs up through the read stage into s_tready.
//
module palette_rle_row_decoder_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire         clk,
  input  wire         rst,
  // stream in
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,  // [7:0] byte_value, [14:8] palette_index,
                                // [38:15] palette_rgb, [39] zero
  input  wire         s_tuser,  // [0] mode
  // stream out
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,  // [31:0] pixel_argb, [39:32] run_length,
                                // [51:40] row_number, [63:52] start_column
  output logic [1:0]  m_tuser,  // [0] row_done, [1] overrun
  output logic        m_tlast,  // image_done
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RB     = prd_pkg::REG_BITS;
  localparam int unsigned IB     = prd_pkg::INDEX_BITS;
  localparam int unsigned CB     = COORD_BITS;
  // wide enough for column + 255 and for the 12-bit registers
  localparam int unsigned CMP_W  = (CB + 1 > RB) ? CB + 1 : RB;

  // ---------------- configuration ----------------
  logic [RB-1:0] row_width;
  logic [RB-1:0] image_height;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= prd_pkg::ROW_WIDTH_RESET;
      image_height <= prd_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        prd_pkg::REG_ROW_WIDTH:    row_width    <= pwdata[RB-1:0];
        prd_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[RB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      prd_pkg::REG_ROW_WIDTH:    prdata = {{(32-RB){1'b0}}, row_width};
      prd_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-RB){1'b0}}, image_height};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- input decode ----------------
  logic [7:0]                   in_byte;
  logic [IB-1:0]                in_pal_index;
  logic [prd_pkg::RGB_BITS-1:0] in_pal_rgb;
  logic                         in_xfer;
  logic                         in_stream;

  assign in_byte      = s_tdata[7:0];
  assign in_pal_index = s_tdata[14:8];
  assign in_pal_rgb   = s_tdata[38:15];
  assign in_xfer      = s_tvalid && s_tready;
  assign in_stream    = (s_tuser == prd_pkg::MODE_STREAM);

  // ---------------- decoder state ----------------
  logic          escape_pending, escape_pending_next;
  logic [IB-1:0] pending_color,  pending_color_next;
  logic [CB-1:0] column_pos,     column_pos_next;
  logic [CB-1:0] row_pos,        row_pos_next;

  logic          emit;
  logic [IB-1:0] run_color;
  logic [7:0]    run_len;
  logic [CMP_W-1:0] run_end;
  logic          run_rdone, run_over, run_idone;

  always_comb begin
    run_len   = escape_pending ? in_byte : 8'd1;
    run_color = escape_pending ? pending_color : in_byte[IB-1:0];
    run_end   = CMP_W'(column_pos) + CMP_W'(run_len);
    run_rdone = (run_end >= CMP_W'(row_width));
    run_over  = (run_end >  CMP_W'(row_width));
    run_idone = run_rdone && ((CMP_W'(row_pos) + CMP_W'(1)) >= CMP_W'(image_height));
    emit      = in_xfer && in_stream && (escape_pending || !in_byte[7]);

    escape_pending_next = escape_pending;
    pending_color_next  = pending_color;
    column_pos_next     = column_pos;
    row_pos_next        = row_pos;
    if (in_xfer && in_stream) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (in_byte[7]) begin
        escape_pending_next = 1'b1;
        pending_color_next  = in_byte[IB-1:0];
      end
    end
    if (emit) begin
      if (run_rdone) begin
        column_pos_next = '0;
        row_pos_next    = run_idone ? '0 : row_pos + CB'(1);
      end else begin
        column_pos_next = run_end[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      pending_color  <= '0;
      column_pos     <= '0;
      row_pos        <= '0;
    end else begin
      escape_pending <= escape_pending_next;
      pending_color  <= pending_color_next;
      column_pos     <= column_pos_next;
      row_pos        <= row_pos_next;
    end
  end

  // ---------------- palette RAM ----------------
  // Writes and reads are both issued at input transfer, one item per cycle
  // while s_tready is high, so a read always sees every earlier palette write.
  logic [prd_pkg::RGB_BITS-1:0] pal_rd_data;

  prd_ram #(
    .WIDTH (prd_pkg::RGB_BITS),
    .DEPTH (prd_pkg::PAL_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (in_xfer && !in_stream),
    .wr_addr (in_pal_index),
    .wr_data (in_pal_rgb),
    .rd_en   (emit),
    .rd_addr (run_color),
    .rd_data (pal_rd_data)
  );

  // ---------------- read stage ----------------
  typedef struct packed {
    logic          transparent;
    logic [7:0]    len;
    logic [RB-1:0] row;
    logic [RB-1:0] col;
    logic          rdone;
    logic          idone;
    logic          over;
  } run_meta_t;

  run_meta_t s1_meta;
  logic      s1_valid;
  logic      s1_adv;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (emit) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_meta.transparent <= (run_color == '0);
      s1_meta.len         <= run_len;
      s1_meta.row         <= RB'(row_pos);
      s1_meta.col         <= RB'(column_pos);
      s1_meta.rdone       <= run_rdone;
      s1_meta.idone       <= run_idone;
      s1_meta.over        <= run_over;
    end
  end

  // ---------------- output register ----------------
  logic [31:0] out_pixel;
  run_meta_t   out_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_pixel <= s1_meta.transparent ? 32'd0 : {prd_pkg::ALPHA_OPAQUE, pal_rd_data};
      out_meta  <= s1_meta;
    end
  end

  assign m_tdata = {out_meta.col, out_meta.row, out_meta.len, out_pixel};
  assign m_tuser = {out_meta.over, out_meta.rdone};
  assign m_tlast = out_meta.idone;

  // ---------------- assertions ----------------
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_meta)))
    else $error("read stage lost or changed a stalled run");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> s1_valid)
    else $error("emitted run did not enter read stage");

  a_over_rdone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_meta.over) |-> out_meta.rdone)
    else $error("overrun without row end");

  a_idone_rdone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_meta.idone) |-> out_meta.rdone)
    else $error("image end without row end");

endmodule
`default_nettype wire

FILE: tb/palette_rle_row_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_rle_row_decoder_unit_tb: self-checking bench for the RLE row decoder
// Loads the palette, walks a directed table of codes and register settings,
// then streams random well-formed code sequences under several idle/stall
// mixes. Every run on m_* is compared against the table's expected run or an in-bench decoder model.
// ----------------------------------------------------------------------------
module palette_rle_row_decoder_unit_tb;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_value;
    logic [6:0]  palette_index;
    logic [23:0] palette_rgb;
  } stream_item_t;

  typedef struct packed {
    logic [31:0] argb;
    logic [7:0]  len;
    logic [11:0] row;
    logic [11:0] col;
    logic        row_done;
    logic        image_done;
    logic        overrun;
  } run_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         cfg_reg;
    logic [11:0]  cfg_val;
    stream_item_t item;
    logic         typed;
    run_t         run;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [7:0] byte_value, [14:8] palette_index,
                              // [38:15] palette_rgb, [39] zero
  logic        s_tuser = 1'b0;  // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;  // [31:0] pixel_argb, [39:32] run_length,
                         // [51:40] row_number, [63:52] start_column
  logic [1:0]  m_tuser;  // [0] row_done, [1] overrun
  logic        m_tlast;  // image_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  palette_rle_row_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [23:0] pal_rgb [prd_pkg::PAL_DEPTH];
  logic        esc_pending = 1'b0;
  logic [6:0]  esc_color = '0;
  logic [11:0] col_pos = '0;
  logic [11:0] row_pos = '0;
  logic [11:0] cfg_width = prd_pkg::ROW_WIDTH_RESET;
  logic [11:0] cfg_height = prd_pkg::IMAGE_HEIGHT_RESET;

  run_t     runs_due [$];
  dir_row_t dir_rows [$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  logic     pressure_req = 1'b0;
  logic     pressure_taken = 1'b0;
  int       hold_left = 0;

  function automatic run_t build_run(input logic [6:0] color, input logic [7:0] len);
    run_t        r;
    int unsigned stop;
    r.argb = (color == 7'd0) ? 32'd0 : {prd_pkg::ALPHA_OPAQUE, pal_rgb[color]};
    r.len = len;
    r.row = row_pos;
    r.col = col_pos;
    stop = col_pos + len;
    r.row_done = (stop >= cfg_width);
    r.overrun = (stop > cfg_width);
    r.image_done = 1'b0;
    if (r.row_done) begin
      if (row_pos + 1 >= cfg_height) begin
        r.image_done = 1'b1;
        row_pos = '0;
      end else begin
        row_pos = row_pos + 12'd1;
      end
      col_pos = '0;
    end else begin
      col_pos = stop[11:0];
    end
    return r;
  endfunction

  function automatic bit predict_run(input stream_item_t it, output run_t r);
    r = '0;
    if (it.mode == prd_pkg::MODE_PALETTE) begin
      pal_rgb[it.palette_index] = it.palette_rgb;
      return 1'b0;
    end
    // byte after an escape is the count, whatever its top bit
    if (esc_pending) begin
      esc_pending = 1'b0;
      r = build_run(esc_color, it.byte_value);
      return 1'b1;
    end
    if (it.byte_value[7]) begin
      esc_pending = 1'b1;
      esc_color = it.byte_value[6:0];
      return 1'b0;
    end
    r = build_run(it.byte_value[6:0], 8'd1);
    return 1'b1;
  endfunction

  function automatic stream_item_t make_item(input logic mode, input logic [7:0] b,
                                             input logic [6:0] idx, input logic [23:0] rgb);
    stream_item_t it;
    it.mode = mode;
    it.byte_value = b;
    it.palette_index = idx;
    it.palette_rgb = rgb;
    return it;
  endfunction

  function automatic void row_item(input logic mode, input logic [7:0] b,
                                   input logic [6:0] idx, input logic [23:0] rgb);
    dir_row_t d;
    d = '0;
    d.kind = ROW_ITEM;
    d.item = make_item(mode, b, idx, rgb);
    dir_rows.push_back(d);
  endfunction

  function automatic void row_run(input logic [7:0] b, input logic [31:0] argb,
                                  input logic [7:0] len, input logic [11:0] rnum,
                                  input logic [11:0] col, input logic rd, id, ov);
    dir_row_t d;
    d = '0;
    d.kind = ROW_ITEM;
    d.item = make_item(prd_pkg::MODE_STREAM, b, 7'd0, 24'd0);
    d.typed = 1'b1;
    d.run = '{argb, len, rnum, col, rd, id, ov};
    dir_rows.push_back(d);
  endfunction

  function automatic void row_cfg(input logic reg_sel, input logic [11:0] val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.cfg_reg = reg_sel;
    d.cfg_val = val;
    dir_rows.push_back(d);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // sender: called and returns right after a rising edge
  task automatic send_item(input stream_item_t it, input logic typed, input run_t typed_run);
    run_t r;
    bit   has;
    has = predict_run(it, r);
    if (has) runs_due.push_back(typed ? typed_run : r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, it.palette_rgb, it.palette_index, it.byte_value};
    s_tuser <= it.mode;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic send_random(input logic mode, input logic [7:0] b);
    send_item(make_item(mode, b, 7'($urandom), 24'($urandom)), 1'b0, '0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    // escape and palette items leave no run behind; let the read stage settle
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [11:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {20'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    check_field(reg_sel == prd_pkg::REG_ROW_WIDTH ? "row_width readback"
                                                   : "image_height readback",
                {20'd0, val}, {20'd0, prdata[prd_pkg::REG_BITS-1:0]});
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == prd_pkg::REG_ROW_WIDTH) cfg_width = val;
    else cfg_height = val;
    @(posedge clk);
  endtask

  task automatic random_items(input int n_items);
    int          sent;
    int unsigned pick;
    logic [7:0]  cnt;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_random(prd_pkg::MODE_PALETTE, 8'($urandom));
        sent++;
      end else if (pick < 50) begin
        send_random(prd_pkg::MODE_STREAM, {1'b0, 7'($urandom)});
        sent++;
      end else if (pick < 95) begin
        send_random(prd_pkg::MODE_STREAM, {1'b1, 7'($urandom)});
        if ($urandom_range(19) == 0) begin
          send_random(prd_pkg::MODE_PALETTE, 8'($urandom));
          sent++;
        end
        pick = $urandom_range(99);
        if (pick < 10) cnt = 8'd0;
        else if (pick < 20) cnt = 8'd255;
        else if (pick < 60) cnt = 8'($urandom_range(8, 1));
        else cnt = 8'($urandom);
        send_random(prd_pkg::MODE_STREAM, cnt);
        sent += 2;
      end else begin
        // raw byte, may leave an escape open across the next item
        send_random(prd_pkg::MODE_STREAM, 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [11:0] w, h, input int idle_s, stall_r,
                           input logic press, input int n_items);
    drain();
    apb_write(prd_pkg::REG_ROW_WIDTH, w);
    apb_write(prd_pkg::REG_IMAGE_HEIGHT, h);
    send_idle_pct = idle_s;
    stall_pct <= stall_r;
    if (press) pressure_req <= 1'b1;
    random_items(n_items);
  endtask

  // receiver, with one long hold-off when asked for
  always @(posedge clk) begin
    if (pressure_req && !pressure_taken) begin
      pressure_taken <= 1'b1;
      hold_left <= 80;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // outputs are stable between the falling edge and the transfer edge
  always @(negedge clk) begin : run_mon
    run_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (runs_due.size() == 0) begin
        fail_count++;
        $display("%0t ns: run with none expected, got tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = runs_due.pop_front();
        check_field("pixel_argb", want.argb, m_tdata[31:0]);
        check_field("run_length", {24'd0, want.len}, {24'd0, m_tdata[39:32]});
        check_field("row_number", {20'd0, want.row}, {20'd0, m_tdata[51:40]});
        check_field("start_column", {20'd0, want.col}, {20'd0, m_tdata[63:52]});
        check_field("row_done", {31'd0, want.row_done}, {31'd0, m_tuser[0]});
        check_field("overrun", {31'd0, want.overrun}, {31'd0, m_tuser[1]});
        check_field("image_done", {31'd0, want.image_done}, {31'd0, m_tlast});
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    // reset values: 512 wide, 384 high
    row_item(prd_pkg::MODE_PALETTE, 8'h00, 7'd1, 24'h123456);
    row_item(prd_pkg::MODE_PALETTE, 8'hFF, 7'd127, 24'hFFFFFF);
    row_item(prd_pkg::MODE_PALETTE, 8'h00, 7'd0, 24'hABCDEF);
    row_run(8'h01, 32'hFF123456, 8'd1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    row_run(8'h00, 32'h0, 8'd1, 12'd0, 12'd1, 1'b0, 1'b0, 1'b0);  // transparent
    row_run(8'h7F, 32'hFFFFFFFF, 8'd1, 12'd0, 12'd2, 1'b0, 1'b0, 1'b0);
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h00, 32'hFF123456, 8'd0, 12'd0, 12'd3, 1'b0, 1'b0, 1'b0);  // empty run
    row_item(prd_pkg::MODE_STREAM, 8'hFF, 7'd0, 24'd0);
    // palette change lands between escape and count
    row_item(prd_pkg::MODE_PALETTE, 8'h00, 7'd127, 24'h000000);
    row_run(8'hFF, 32'hFF000000, 8'd255, 12'd0, 12'd3, 1'b0, 1'b0, 1'b0);
    row_item(prd_pkg::MODE_STREAM, 8'h80, 7'd0, 24'd0);
    row_run(8'hFE, 32'h0, 8'd254, 12'd0, 12'd258, 1'b1, 1'b0, 1'b0);  // exact row end
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h80, 32'hFF123456, 8'd128, 12'd1, 12'd0, 1'b0, 1'b0, 1'b0);
    row_cfg(prd_pkg::REG_ROW_WIDTH, 12'd4);
    row_cfg(prd_pkg::REG_IMAGE_HEIGHT, 12'd2);
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h06, 32'hFF123456, 8'd6, 12'd1, 12'd128, 1'b1, 1'b1, 1'b1);  // overrun
    row_run(8'h01, 32'hFF123456, 8'd1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h02, 32'hFF123456, 8'd2, 12'd0, 12'd1, 1'b0, 1'b0, 1'b0);
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h01, 32'hFF123456, 8'd1, 12'd0, 12'd3, 1'b1, 1'b0, 1'b0);
    // zero-sized registers: every run ends the row and the image
    row_cfg(prd_pkg::REG_ROW_WIDTH, 12'd0);
    row_cfg(prd_pkg::REG_IMAGE_HEIGHT, 12'd0);
    row_item(prd_pkg::MODE_STREAM, 8'h81, 7'd0, 24'd0);
    row_run(8'h00, 32'hFF123456, 8'd0, 12'd1, 12'd0, 1'b1, 1'b1, 1'b0);
    row_run(8'h7F, 32'hFF000000, 8'd1, 12'd0, 12'd0, 1'b1, 1'b1, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        apb_write(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].run);
      end
    end

    // fill every palette entry so random codes never read an unwritten one
    for (int i = 0; i < prd_pkg::PAL_DEPTH; i++)
      send_item(make_item(prd_pkg::MODE_PALETTE, 8'($urandom), 7'(i), 24'($urandom)),
                1'b0, '0);

    run_phase(12'd4095, 12'd4095, 0, 0, 1'b1, 105);
    run_phase(12'd1, 12'd1, 69, 0, 1'b0, 105);
    run_phase(12'($urandom_range(40, 1)), 12'($urandom_range(6, 1)), 0, 69, 1'b0, 105);
    run_phase(12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)), 14, 14, 1'b0, 105);
    run_phase(12'($urandom_range(64, 8)), 12'($urandom_range(4, 1)), 0, 0, 1'b0, 105);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/prd_pkg.sv
sv/prd_ram.sv
sv/palette_rle_row_decoder_unit.sv
tb/palette_rle_row_decoder_unit_tb.sv
